@@ rtl/yuv420_quad_to_bgr_top_defines.svh @@
// Shared assertion macros for the colour converter.
`ifndef YUV420_QUAD_TO_BGR_TOP_DEFINES_SVH
`define YUV420_QUAD_TO_BGR_TOP_DEFINES_SVH

// Condition holds, consequence holds in the same cycle.
`define YQB_ASSERT_SAME(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Condition holds, consequence holds in the next cycle.
`define YQB_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/yqbgr_pkg.sv @@
package yqbgr_pkg;

  localparam int FracBitsDef = 16;
  localparam int PixW        = 8;
  localparam int NumLanes    = 4;
  localparam int InDataW     = 48;
  localparam int OutDataW    = 96;

  localparam logic [63:0] CoefRCrMicro = 64'd1370705;
  localparam logic [63:0] CoefGCrMicro = 64'd698001;
  localparam logic [63:0] CoefGCbMicro = 64'd337633;
  localparam logic [63:0] CoefBCbMicro = 64'd1732446;

  // round a coefficient given in millionths to nearest fixed point
  function automatic logic [63:0] to_fixed(input logic [63:0] millionths, input int frac);
    return ((millionths << frac) + 64'd500000) / 64'd1000000;
  endfunction

endpackage

@@ rtl/yqbgr_chroma.sv @@
module yqbgr_chroma #(
  parameter int FRAC_BITS = yqbgr_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [7:0]                    chroma_blue_i,
  input  logic [7:0]                    chroma_red_i,
  output logic signed [FRAC_BITS+11:0]  term_r_o,
  output logic signed [FRAC_BITS+11:0]  term_gr_o,
  output logic signed [FRAC_BITS+11:0]  term_gb_o,
  output logic signed [FRAC_BITS+11:0]  term_b_o
);

  localparam int CoefW = FRAC_BITS + 2;
  localparam int AccW  = FRAC_BITS + 12;

  localparam logic [CoefW-1:0] CoefRCr =
    CoefW'(yqbgr_pkg::to_fixed(yqbgr_pkg::CoefRCrMicro, FRAC_BITS));
  localparam logic [CoefW-1:0] CoefGCr =
    CoefW'(yqbgr_pkg::to_fixed(yqbgr_pkg::CoefGCrMicro, FRAC_BITS));
  localparam logic [CoefW-1:0] CoefGCb =
    CoefW'(yqbgr_pkg::to_fixed(yqbgr_pkg::CoefGCbMicro, FRAC_BITS));
  localparam logic [CoefW-1:0] CoefBCb =
    CoefW'(yqbgr_pkg::to_fixed(yqbgr_pkg::CoefBCbMicro, FRAC_BITS));

  logic signed [8:0]      db, dr;
  logic signed [AccW-1:0] term_r_d, term_gr_d, term_gb_d, term_b_d;
  logic signed [AccW-1:0] term_r_q, term_gr_q, term_gb_q, term_b_q;

  // remove the offset of 128
  assign db = {~chroma_blue_i[7], ~chroma_blue_i[7], chroma_blue_i[6:0]};
  assign dr = {~chroma_red_i[7], ~chroma_red_i[7], chroma_red_i[6:0]};

  assign term_r_d  = AccW'(dr) * AccW'($signed({1'b0, CoefRCr}));
  assign term_gr_d = AccW'(dr) * AccW'($signed({1'b0, CoefGCr}));
  assign term_gb_d = AccW'(db) * AccW'($signed({1'b0, CoefGCb}));
  assign term_b_d  = AccW'(db) * AccW'($signed({1'b0, CoefBCb}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_r_q  <= term_r_d;
      term_gr_q <= term_gr_d;
      term_gb_q <= term_gb_d;
      term_b_q  <= term_b_d;
    end
  end

  assign term_r_o  = term_r_q;
  assign term_gr_o = term_gr_q;
  assign term_gb_o = term_gb_q;
  assign term_b_o  = term_b_q;

endmodule

@@ rtl/yqbgr_lane.sv @@
module yqbgr_lane #(
  parameter int FRAC_BITS = yqbgr_pkg::FracBitsDef
) (
  input  logic [7:0]                   luma_i,
  input  logic signed [FRAC_BITS+11:0] term_r_i,
  input  logic signed [FRAC_BITS+11:0] term_gr_i,
  input  logic signed [FRAC_BITS+11:0] term_gb_i,
  input  logic signed [FRAC_BITS+11:0] term_b_i,
  output logic [23:0]                  bgr_o   // blue, green, red from the lowest bit up
);

  localparam int AccW = FRAC_BITS + 12;

  logic signed [AccW-1:0] ybase, sum_r, sum_g, sum_b;
  logic [7:0]             red, green, blue;

  function automatic logic [7:0] floor_clamp(input logic signed [AccW-1:0] acc);
    logic [AccW-FRAC_BITS-2:0] whole;
    whole = acc[AccW-2:FRAC_BITS];
    if (acc[AccW-1]) begin
      return 8'd0;
    end else if (|whole[AccW-FRAC_BITS-2:8]) begin
      return 8'hff;
    end else begin
      return whole[7:0];
    end
  endfunction

  assign ybase = $signed({4'd0, luma_i, {FRAC_BITS{1'b0}}});
  assign sum_r = ybase + term_r_i;
  assign sum_g = ybase - term_gr_i - term_gb_i;
  assign sum_b = ybase + term_b_i;

  assign red   = floor_clamp(sum_r);
  assign green = floor_clamp(sum_g);
  assign blue  = floor_clamp(sum_b);

  assign bgr_o = {red, green, blue};

endmodule

@@ rtl/yuv420_quad_to_bgr_top.sv @@
// channel  | direction | payload
// s_axis   | in        | one 2x2 block: four luma bytes, blue and red chroma
// m_axis   | out       | blue, green, red of the four pixels
// One word in every cycle unless stalled; it passes stage one, then the output register.
// Stage one holds luma and four shared chroma products, stage two the clamped pixels.
// Reset clears the stage valid flags only.
// A stalled output holds both stages; input is still taken while stage one is free.
module yuv420_quad_to_bgr_top #(
  parameter int FRAC_BITS = yqbgr_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // chroma_blue, chroma_red
  input  logic [47:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // blue/green/red top_left, top_right, bottom_left, bottom_right
  output logic [95:0]  m_axis_tdata
);

  `include "yuv420_quad_to_bgr_top_defines.svh"

  localparam int AccW = FRAC_BITS + 12;

  logic                   s1_valid_q, s1_valid_d;
  logic                   m_valid_q, m_valid_d;
  logic                   s_hs, adv1, adv2;
  logic [31:0]            luma_q;
  logic [95:0]            pix_d, pix_q;
  logic signed [AccW-1:0] term_r, term_gr, term_gb, term_b;

  assign adv2          = !m_valid_q || m_axis_tready;
  assign adv1          = s1_valid_q && adv2;
  assign s_axis_tready = !s1_valid_q || adv2;
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  assign s1_valid_d = s_hs || (s1_valid_q && !adv2);
  assign m_valid_d  = adv1 || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      luma_q <= s_axis_tdata[31:0];
    end
    if (adv1) begin
      pix_q <= pix_d;
    end
  end

  yqbgr_chroma #(
    .FRAC_BITS(FRAC_BITS)
  ) u_chroma (
    .clk_i        (clk_i),
    .en_i         (s_hs),
    .chroma_blue_i(s_axis_tdata[39:32]),
    .chroma_red_i (s_axis_tdata[47:40]),
    .term_r_o     (term_r),
    .term_gr_o    (term_gr),
    .term_gb_o    (term_gb),
    .term_b_o     (term_b)
  );

  for (genvar k = 0; k < yqbgr_pkg::NumLanes; k++) begin : g_lane
    yqbgr_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .luma_i   (luma_q[k*8 +: 8]),
      .term_r_i (term_r),
      .term_gr_i(term_gr),
      .term_gb_i(term_gb),
      .term_b_i (term_b),
      .bgr_o    (pix_d[k*24 +: 24])
    );
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = pix_q;

  `YQB_ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, s_hs, s1_valid_q)
  `YQB_ASSERT_NEXT(a_s1_moves_out, clk_i, rst_ni, adv1, m_valid_q)
  `YQB_ASSERT_NEXT(a_s1_holds, clk_i, rst_ni, s1_valid_q && !adv2, s1_valid_q)
  `YQB_ASSERT_SAME(a_full_stalls, clk_i, rst_ni,
                   s1_valid_q && m_valid_q && !m_axis_tready, !s_axis_tready)

endmodule

@@ dv/tb_yuv420_quad_to_bgr_top.sv @@
module tb_yuv420_quad_to_bgr_top;

  import yqbgr_pkg::*;

  localparam int FracBits      = FracBitsDef;
  localparam int WatchdogLimit = 2000;
  localparam int StallCycles   = 200;
  localparam int RandomPerPass = 150;

  typedef struct packed {
    logic [InDataW-1:0]  word;
    logic                known;
    logic [OutDataW-1:0] bgr;
  } quad_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [OutDataW-1:0] bgr_q[$];
  quad_row_t           quad_rows[16];
  int                  err_cnt;
  int                  idle_cycles;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  bit                  stall_req;

  yuv420_quad_to_bgr_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic longint coef_fixed(input longint micro);
    return ((micro << FracBits) + 64'sd500000) / 64'sd1000000;
  endfunction

  function automatic logic [PixW-1:0] clamp_channel(input longint acc);
    if (acc < 0) return '0;
    if ((acc >>> FracBits) > 255) return 8'hFF;
    return PixW'(acc >>> FracBits);
  endfunction

  function automatic logic [OutDataW-1:0] predict_bgr(input logic [InDataW-1:0] word);
    logic [OutDataW-1:0] bgr;
    longint              d_blue;
    longint              d_red;
    longint              base;
    d_blue = longint'(word[4*PixW +: PixW]) - 128;
    d_red  = longint'(word[5*PixW +: PixW]) - 128;
    for (int k = 0; k < NumLanes; k++) begin
      base = longint'(word[k*PixW +: PixW]) << FracBits;
      bgr[(3*k)*PixW +: PixW]   = clamp_channel(base + coef_fixed(longint'(CoefBCbMicro)) * d_blue);
      bgr[(3*k+1)*PixW +: PixW] = clamp_channel(base
                                    - coef_fixed(longint'(CoefGCrMicro)) * d_red
                                    - coef_fixed(longint'(CoefGCbMicro)) * d_blue);
      bgr[(3*k+2)*PixW +: PixW] = clamp_channel(base + coef_fixed(longint'(CoefRCrMicro)) * d_red);
    end
    return bgr;
  endfunction

  function automatic logic [PixW-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'h81;
      5:       return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [InDataW-1:0] rand_quad();
    logic [InDataW-1:0] word;
    word = {16'($urandom), 32'($urandom)};
    case ($urandom_range(0, 3))
      2: begin
        word[4*PixW +: PixW] = pick_extreme();
        word[5*PixW +: PixW] = pick_extreme();
      end
      3: begin
        for (int k = 0; k < NumLanes; k++) word[k*PixW +: PixW] = pick_extreme();
      end
      default: ;
    endcase
    return word;
  endfunction

  task automatic send_quad(input logic [InDataW-1:0] word, input logic known,
                           input logic [OutDataW-1:0] bgr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    bgr_q.push_back(known ? bgr : predict_bgr(word));
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (bgr_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_quad(rand_quad(), 1'b0, '0);
  endtask

  // tdata packs {cr, cb, br, bl, tr, tl}; only neutral chroma rows carry a fixed answer
  initial begin
    quad_rows[0]  = {48'h80_80_00_00_00_00, 1'b1, 96'h000000_000000_000000_000000};
    quad_rows[1]  = {48'h80_80_FF_FF_FF_FF, 1'b1, 96'hFFFFFF_FFFFFF_FFFFFF_FFFFFF};
    quad_rows[2]  = {48'h80_80_01_80_FF_00, 1'b1, 96'h010101_808080_FFFFFF_000000};
    quad_rows[3]  = {48'h80_80_AA_55_AA_55, 1'b1, 96'hAAAAAA_555555_AAAAAA_555555};
    quad_rows[4]  = {48'h00_00_00_00_00_00, 1'b0, 96'h0};
    quad_rows[5]  = {48'hFF_FF_FF_FF_FF_FF, 1'b0, 96'h0};
    quad_rows[6]  = {48'h00_FF_FF_00_FF_00, 1'b0, 96'h0};
    quad_rows[7]  = {48'hFF_00_00_FF_00_FF, 1'b0, 96'h0};
    quad_rows[8]  = {48'h7F_81_40_C0_10_F0, 1'b0, 96'h0};
    quad_rows[9]  = {48'h81_7F_C0_40_F0_10, 1'b0, 96'h0};
    quad_rows[10] = {48'h80_00_FF_FF_FF_FF, 1'b0, 96'h0};
    quad_rows[11] = {48'h80_FF_00_00_00_00, 1'b0, 96'h0};
    quad_rows[12] = {48'h00_80_00_00_00_00, 1'b0, 96'h0};
    quad_rows[13] = {48'hFF_80_FF_FF_FF_FF, 1'b0, 96'h0};
    quad_rows[14] = {48'h81_81_01_01_01_01, 1'b0, 96'h0};
    quad_rows[15] = {48'h7F_7F_00_01_FE_FF, 1'b0, 96'h0};
  end

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        // hold off the output so the pipe fills and backs up the input
        m_axis_tready <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
        stall_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_bgr
    logic [OutDataW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (bgr_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, m_axis_tdata);
        err_cnt++;
      end else begin
        want = bgr_q.pop_front();
        for (int k = 0; k < 3*NumLanes; k++) begin
          if (m_axis_tdata[k*PixW +: PixW] !== want[k*PixW +: PixW]) begin
            $display("%0t: pixel %0d channel %0d expected %02h got %02h", $time, k/3, k%3,
                     want[k*PixW +: PixW], m_axis_tdata[k*PixW +: PixW]);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    err_cnt       = 0;
    idle_cycles   = 0;
    stall_req     = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 57;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 16; i++) begin
      send_quad(quad_rows[i].word, quad_rows[i].known, quad_rows[i].bgr);
    end
    send_random(RandomPerPass);
    drain_pipe();

    send_idle_pct = 57;
    recv_idle_pct = 17;
    send_random(RandomPerPass);
    drain_pipe();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req     = 1'b1;
    send_random(RandomPerPass);
    drain_pipe();

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
